// ===== sv/nbt_pkg.sv =====
// ----------------------------------------------------------------------------
// nbt_pkg
// Shared widths and codes for the naive Bayes pixel trainer.
// ----------------------------------------------------------------------------
package nbt_pkg;

  localparam int OP_BITS    = 2;
  localparam int COORD_BITS = 5;
  localparam int LABEL_BITS = 4;
  localparam int K_BITS     = 8;
  localparam int PROB_BITS  = 16;
  localparam int TOTAL_BITS = 20;

  localparam logic [K_BITS-1:0] K_RESET = 8'd16;

  localparam logic [OP_BITS-1:0] OP_TRAIN      = 2'd0;
  localparam logic [OP_BITS-1:0] OP_LIKELIHOOD = 2'd1;
  localparam logic [OP_BITS-1:0] OP_PRIOR      = 2'd2;

  localparam logic STATUS_OK  = 1'b0;
  localparam logic STATUS_ERR = 1'b1;

endpackage

// ===== sv/nbt_req_if.sv =====
// ----------------------------------------------------------------------------
// nbt_req_if
// Request channel: one pixel to train on, or one probability query.
// ----------------------------------------------------------------------------
interface nbt_req_if;
  logic                            valid;
  logic                            ready;
  logic [nbt_pkg::OP_BITS-1:0]     op;
  logic [nbt_pkg::COORD_BITS-1:0]  pixel_x;
  logic [nbt_pkg::COORD_BITS-1:0]  pixel_y;
  logic                            shade;
  logic [nbt_pkg::LABEL_BITS-1:0]  class_label;
  logic                            image_start;

  modport source (
    output valid, op, pixel_x, pixel_y, shade, class_label, image_start,
    input  ready
  );
  modport sink (
    input  valid, op, pixel_x, pixel_y, shade, class_label, image_start,
    output ready
  );
endinterface

// ===== sv/nbt_rsp_if.sv =====
// ----------------------------------------------------------------------------
// nbt_rsp_if
// Response channel: one probability and status per request.
// ----------------------------------------------------------------------------
interface nbt_rsp_if;
  logic                           valid;
  logic                           ready;
  logic [nbt_pkg::PROB_BITS-1:0]  probability;
  logic                           status;

  modport source (output valid, probability, status, input ready);
  modport sink   (input valid, probability, status, output ready);
endinterface

// ===== sv/naive_bayes_pixel_trainer.sv =====
// ----------------------------------------------------------------------------
// naive_bayes_pixel_trainer
// After reset the block sweeps all IMG_W*IMG_H*SHADES*LABELS entries of its
// pixel count RAM (15680 at the defaults) to zero, one entry per cycle, and
// holds req.ready low meanwhile. It then takes one request at a time. The
// response to a train request, or to any request with a bad index or op, is
// valid after RAM lookup, update and load into the output register. A valid
// likelihood or prior query goes through the shared divider after the lookup,
// which pins the quotient at full scale if it is one or more or the divisor
// is zero, and else produces the 16 quotient bits one at a time. req.ready
// rises together with the response valid. If the previous response is still
// unclaimed, the load into the output register waits, and req.ready stays low,
// until that response is taken.
// A finished response waits in an output register, so the next request may be
// accepted before it is taken. smoothing_k may be written whenever no request
// is in flight.
// ----------------------------------------------------------------------------
module naive_bayes_pixel_trainer #(
  parameter int IMG_W      = 28,
  parameter int IMG_H      = 28,
  parameter int LABELS     = 10,
  parameter int SHADES     = 2,
  parameter int COUNT_BITS = 16
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_wr_en,
  input  logic [nbt_pkg::K_BITS-1:0]   cfg_wr_data,
  nbt_req_if.sink                      req,
  nbt_rsp_if.source                    rsp
);

  localparam int PIX_DEPTH = IMG_W * IMG_H * SHADES * LABELS;
  localparam int ADDR_W    = $clog2(PIX_DEPTH);
  localparam int LBL_W     = $clog2(LABELS);
  localparam int TB        = nbt_pkg::TOTAL_BITS;
  localparam int MAXB      = (COUNT_BITS > TB) ? COUNT_BITS : TB;
  localparam int OPW       = MAXB + 5;

  typedef enum logic [2:0] {CLEAR, IDLE, LOOKUP, CALC, WAIT_DIV, FINISH} state_t;

  state_t                        state;
  logic [nbt_pkg::K_BITS-1:0]    smoothing_k;
  logic [nbt_pkg::OP_BITS-1:0]   op_r;
  logic [LBL_W-1:0]              lab_r;
  logic                          start_r;
  logic                          pix_ok_r;
  logic                          lab_ok_r;
  logic [ADDR_W-1:0]             addr_r;
  logic [ADDR_W-1:0]             clr_addr;
  logic [COUNT_BITS-1:0]         label_cnt [LABELS];
  logic [TB-1:0]                 total_cnt;
  logic [nbt_pkg::PROB_BITS-1:0] res_prob;
  logic                          res_status;
  logic                          out_valid;
  logic [nbt_pkg::PROB_BITS-1:0] out_prob;
  logic                          out_status;

  // request decode
  logic              in_lab_ok;
  logic              in_pix_ok;
  logic [ADDR_W-1:0] in_addr;

  assign in_lab_ok = 32'(req.class_label) < LABELS;
  assign in_pix_ok = in_lab_ok && 32'(req.pixel_x) < IMG_W &&
                     32'(req.pixel_y) < IMG_H && 32'(req.shade) < SHADES;
  assign in_addr   = ADDR_W'(((32'(req.pixel_y) * IMG_W + 32'(req.pixel_x)) * SHADES
                     + 32'(req.shade)) * LABELS + 32'(req.class_label));

  // pixel count RAM
  logic                  ram_we;
  logic [ADDR_W-1:0]     ram_waddr;
  logic [COUNT_BITS-1:0] ram_wdata;
  logic [COUNT_BITS-1:0] ram_rdata;
  logic [COUNT_BITS-1:0] cnt_inc;
  logic                  train_ok;

  assign train_ok  = op_r == nbt_pkg::OP_TRAIN && pix_ok_r;
  assign cnt_inc   = (ram_rdata == '1) ? ram_rdata : ram_rdata + 1'b1;
  assign ram_we    = (state == CLEAR) || (state == CALC && train_ok);
  assign ram_waddr = (state == CLEAR) ? clr_addr : addr_r;
  assign ram_wdata = (state == CLEAR) ? '0 : cnt_inc;

  nbt_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (PIX_DEPTH)
  ) u_pix_ram (
    .clk     (clk),
    .wr_en   (ram_we),
    .wr_addr (ram_waddr),
    .wr_data (ram_wdata),
    .rd_addr (addr_r),
    .rd_data (ram_rdata)
  );

  // divider operands, Q21.4
  logic [COUNT_BITS-1:0]         imgs;
  logic [OPW-1:0]                div_num;
  logic [OPW-1:0]                div_den;
  logic                          is_like;
  logic                          query_ok;
  logic                          div_start;
  logic                          div_done;
  logic [nbt_pkg::PROB_BITS-1:0] div_quot;

  assign imgs     = label_cnt[lab_r];
  assign is_like  = op_r == nbt_pkg::OP_LIKELIHOOD;
  assign query_ok = (is_like && pix_ok_r) || (op_r == nbt_pkg::OP_PRIOR && lab_ok_r);

  always_comb begin
    if (is_like) begin
      div_num = OPW'(smoothing_k) + (OPW'(ram_rdata) << 4);
      div_den = OPW'(OPW'(SHADES) * OPW'(smoothing_k)) + (OPW'(imgs) << 4);
    end else begin
      div_num = OPW'(smoothing_k) + (OPW'(imgs) << 4);
      div_den = OPW'(OPW'(LABELS) * OPW'(smoothing_k)) + (OPW'(total_cnt) << 4);
    end
  end

  assign div_start = (state == CALC) && query_ok;

  nbt_div #(
    .OPW (OPW)
  ) u_div (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      smoothing_k <= nbt_pkg::K_RESET;
    end else if (cfg_wr_en) begin
      smoothing_k <= cfg_wr_data;
    end
  end

  // image counters
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < LABELS; i++) begin
        label_cnt[i] <= '0;
      end
      total_cnt <= '0;
    end else if (state == CALC && train_ok && start_r) begin
      if (imgs != '1) begin
        label_cnt[lab_r] <= imgs + 1'b1;
      end
      if (total_cnt != '1) begin
        total_cnt <= total_cnt + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= CLEAR;
      clr_addr  <= '0;
      out_valid <= 1'b0;
    end else begin
      // drop the taken response unless FINISH loads a new one
      if (rsp.ready && state != FINISH) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        CLEAR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == ADDR_W'(PIX_DEPTH - 1)) begin
            state <= IDLE;
          end
        end
        IDLE: begin
          if (req.valid) begin
            op_r     <= req.op;
            lab_r    <= in_lab_ok ? LBL_W'(req.class_label) : '0;
            start_r  <= req.image_start;
            pix_ok_r <= in_pix_ok;
            lab_ok_r <= in_lab_ok;
            addr_r   <= in_addr;
            state    <= LOOKUP;
          end
        end
        LOOKUP: state <= CALC;
        CALC: begin
          res_prob   <= '0;
          res_status <= train_ok ? nbt_pkg::STATUS_OK : nbt_pkg::STATUS_ERR;
          state      <= query_ok ? WAIT_DIV : FINISH;
        end
        WAIT_DIV: begin
          if (div_done) begin
            res_prob   <= div_quot;
            res_status <= nbt_pkg::STATUS_OK;
            state      <= FINISH;
          end
        end
        FINISH: begin
          // hold until the output register is free
          if (!out_valid || rsp.ready) begin
            out_valid  <= 1'b1;
            out_prob   <= res_prob;
            out_status <= res_status;
            state      <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign req.ready       = state == IDLE;
  assign rsp.valid       = out_valid;
  assign rsp.probability = out_prob;
  assign rsp.status      = out_status;

endmodule

// ===== sv/nbt_ram.sv =====
// ----------------------------------------------------------------------------
// nbt_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module nbt_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ===== sv/nbt_div.sv =====
// ----------------------------------------------------------------------------
// nbt_div
// Restoring fraction divider: Q0.16 quotient of num/den, one bit per cycle.
// ----------------------------------------------------------------------------
module nbt_div #(
  parameter int OPW = 25
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [OPW-1:0]                num,
  input  logic [OPW-1:0]                den,
  output logic                          done,
  output logic [nbt_pkg::PROB_BITS-1:0] quot
);

  localparam int QB    = nbt_pkg::PROB_BITS;
  localparam int CNT_W = $clog2(QB);

  typedef enum logic [1:0] {D_IDLE, D_CHECK, D_STEP} dstate_t;

  dstate_t          state;
  logic [OPW-1:0]   rem;
  logic [OPW-1:0]   den_r;
  logic [CNT_W-1:0] cnt;
  logic [OPW:0]     shifted;
  logic             fits;

  assign shifted = {rem, 1'b0};
  assign fits    = shifted >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= D_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        D_IDLE: begin
          if (start) begin
            rem   <= num;
            den_r <= den;
            state <= D_CHECK;
          end
        end
        D_CHECK: begin
          // quotient of one or more, or no divisor: pin at full scale
          if (den_r == '0 || rem >= den_r) begin
            quot  <= '1;
            done  <= 1'b1;
            state <= D_IDLE;
          end else begin
            cnt   <= '0;
            state <= D_STEP;
          end
        end
        D_STEP: begin
          if (fits) begin
            rem <= OPW'(shifted - {1'b0, den_r});
          end else begin
            rem <= shifted[OPW-1:0];
          end
          quot <= {quot[QB-2:0], fits};
          cnt  <= cnt + 1'b1;
          if (cnt == CNT_W'(QB - 1)) begin
            done  <= 1'b1;
            state <= D_IDLE;
          end
        end
        default: state <= D_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/nbt_chk.sv =====
// ----------------------------------------------------------------------------
// nbt_chk
// Port-level checks for the naive Bayes pixel trainer.
// ----------------------------------------------------------------------------
module nbt_chk (
  input logic                          clk,
  input logic                          rst,
  input logic                          req_valid,
  input logic                          req_ready,
  input logic                          rsp_valid,
  input logic                          rsp_ready,
  input logic [nbt_pkg::PROB_BITS-1:0] probability,
  input logic                          status
);

  // the clear sweep keeps requests out right after reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !req_ready && !rsp_valid)
    else $error("request or response open right after reset");

  // each request keeps the sequencer busy, so ready drops once it is taken
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while previous one is in flight");

  a_error_zero: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && status == nbt_pkg::STATUS_ERR |-> probability == '0)
    else $error("error response carries a nonzero probability");

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(probability) && $stable(status))
    else $error("stalled response changed");

endmodule

bind naive_bayes_pixel_trainer nbt_chk u_nbt_chk (
  .clk         (clk),
  .rst         (rst),
  .req_valid   (req.valid),
  .req_ready   (req.ready),
  .rsp_valid   (rsp.valid),
  .rsp_ready   (rsp.ready),
  .probability (rsp.probability),
  .status      (rsp.status)
);
